// ===== sv/sector_free_list_allocator_macros.svh =====
// Assertion macros used by the allocator checker
`ifndef SECTOR_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SECTOR_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, held off during reset
`define SFLA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfla check failed");

// Next-cycle implication, held off during reset
`define SFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfla check failed");

`endif

// ===== sv/sfla_pkg.sv =====
// Types and constants shared by the sector free-list allocator
package sfla_pkg;

   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int PCT_W      = 7;
   localparam int TOTAL_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Actions
   localparam logic [ACTION_W-1:0] ACT_ALLOC       = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE        = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_STATS = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_MAINT       = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_THRESH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_ENABLE = 2'd2;

   localparam int SECTOR_COUNT_RESET = 1024;
   localparam int PCT_SCALE          = 100;

   // Percent divider: 8 quotient bits, two per step
   localparam int QUO_W      = 8;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_CNT_W  = 2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  free_idx;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  alloc_index;
      logic [COUNT_W-1:0]  free_count;
      logic [COUNT_W-1:0]  used_count;
      logic [PCT_W-1:0]    used_pct;
      logic [PCT_W-1:0]    peak_percent;
      logic                pressure;
      logic [TOTAL_W-1:0]  alloc_total;
      logic [TOTAL_W-1:0]  free_total;
      logic [TOTAL_W-1:0]  fail_total;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic finish;
   } ctl_cmd_type;

endpackage

// ===== sv/sector_free_list_allocator.sv =====
// Sector free-list allocator top level
// Usage:
//   req channel carries one transaction: action (alloc, free, clear statistics,
//   maintenance) and the sector index for a free. rsp channel returns one
//   transaction per request with status, granted index, free and used counts,
//   usage and peak percent, pressure flag and the three event totals.
//   csr channel writes the pool size (index 0), the pressure threshold (1) and
//   the pressure enable (2); csr_ready is high out of reset. Write it only
//   while idle. Writing the pool size makes every sector free again.
// Timing:
//   After the request is accepted, the stack memory is read at the accepting
//   edge, then the EXEC state does the update, the percent divider runs in
//   the DIV state (two quotient bits per cycle) and the FIN state loads the
//   output register. One request is in flight at a time, so a new request is
//   taken only once the previous result is loaded into the output register.
// Reset and stall:
//   Reset frees every sector, clears counters and peak and restores the
//   register defaults; no clearing pass is needed. If rsp_ready is low the
//   result holds, the next request may still be accepted and runs until its
//   own result waits for the output register.
module sector_free_list_allocator #(
   parameter int MAX_SECTORS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sfla_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sfla_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfla_pkg::*;

   ctl_cmd_type cmd;
   logic        csr_write;

   // Take configuration writes whenever out of reset
   assign csr_ready = !reset;
   assign csr_write = csr_valid && csr_ready;

   sfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sfla_dp #(
      .MAX_SECTORS (MAX_SECTORS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/sfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sfla_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sfla_ctrl.sv =====
// Sequencing state machine for the allocator
module sfla_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sfla_pkg::ctl_cmd_type cmd
);
   import sfla_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 load;

   // Handshake decode; refuse requests while in reset
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // Drive datapath commands
   always_comb begin
      cmd.capture  = accept;
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.finish   = load;
   end

   // Advance state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + DIV_CNT_W'(1);
            if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/sfla_dp.sv =====
// Allocator datapath: stack memory, counters, percent divider, result register
module sfla_dp #(
   parameter int MAX_SECTORS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sfla_pkg::ctl_cmd_type            cmd,
   input  sfla_pkg::req_type                req_data,
   input  logic                             csr_write,
   input  logic [sfla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output sfla_pkg::rsp_type                rsp_data
);
   import sfla_pkg::*;

   localparam int CNT_W     = $clog2(MAX_SECTORS + 1);
   localparam int IDX_W     = $clog2(MAX_SECTORS);
   localparam int NUM_W     = CNT_W + PCT_W;
   localparam int DSH_W     = CNT_W + QUO_W;
   localparam int CNT_RESET = (MAX_SECTORS < SECTOR_COUNT_RESET) ? MAX_SECTORS
                                                                 : SECTOR_COUNT_RESET;

   // Configuration
   logic [CNT_W-1:0]   sc_ff, sc_in;
   logic [PCT_W-1:0]   thr_ff, thr_in;
   logic               pen_ff, pen_in;
   logic [CNT_W-1:0]   sc_clamped;

   // Architectural state
   logic [CNT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   hwm_ff, hwm_in;
   logic [TOTAL_W-1:0] alloc_tot_ff, alloc_tot_in;
   logic [TOTAL_W-1:0] free_tot_ff, free_tot_in;
   logic [TOTAL_W-1:0] fail_tot_ff, fail_tot_in;
   logic [PCT_W-1:0]   peak_ff, peak_in;

   // Per-transaction working registers
   logic [ACTION_W-1:0] act_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    granted_ff, granted_in;
   logic                alloc_ok_ff, alloc_ok_in;

   // Divider
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DSH_W-1:0]   dsh_ff, dsh_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [NUM_W-1:0]   num;
   logic [DSH_W-1:0]   rem_ext, dsh_lo, r1, r0;
   logic               b1, b0;

   // Stack memory
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   wr_data;
   logic [IDX_W-1:0]   rd_data;
   logic [IDX_W-1:0]   top_entry;
   logic [CNT_W-1:0]   head_plus, head_m1;

   logic [PCT_W-1:0]   usage;
   logic               press;
   rsp_type            rsp_ff;

   sfla_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_SECTORS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign head_plus = head_ff + CNT_W'(1);
   assign head_m1   = head_ff - CNT_W'(1);

   // Entries at or above the high-water mark were never written: they hold their own index
   assign top_entry = (head_ff < hwm_ff) ? rd_data : head_ff[IDX_W-1:0];

   // Clamp a written sector count into 1..MAX_SECTORS
   always_comb begin
      priority if (csr_wdata == '0) begin
         sc_clamped = CNT_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_SECTORS)) begin
         sc_clamped = CNT_W'(MAX_SECTORS);
      end else begin
         sc_clamped = CNT_W'(csr_wdata);
      end
   end

   // Usage and pressure from the finished quotient
   assign usage = quo_ff[PCT_W-1:0];
   assign press = pen_ff && (usage >= thr_ff) && (alloc_ok_ff || (act_ff == ACT_MAINT));

   // Update state on configuration writes and request execution
   always_comb begin
      sc_in        = sc_ff;
      thr_in       = thr_ff;
      pen_in       = pen_ff;
      head_in      = head_ff;
      hwm_in       = hwm_ff;
      alloc_tot_in = alloc_tot_ff;
      free_tot_in  = free_tot_ff;
      fail_tot_in  = fail_tot_ff;
      peak_in      = peak_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      alloc_ok_in  = alloc_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = head_m1[IDX_W-1:0];
      wr_data      = IDX_W'(idx_ff);

      if (csr_write) begin
         unique case (csr_index)
            CSR_SECTOR_COUNT: begin
               sc_in   = sc_clamped;
               head_in = '0;
               hwm_in  = '0;
            end
            CSR_PRESS_THRESH: thr_in = csr_wdata[PCT_W-1:0];
            CSR_PRESS_ENABLE: pen_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.exec) begin
         status_in   = STAT_OK;
         granted_in  = '0;
         alloc_ok_in = 1'b0;
         unique case (act_ff)
            ACT_ALLOC: begin
               if (head_ff >= sc_ff) begin
                  fail_tot_in = fail_tot_ff + 1'b1;
                  status_in   = STAT_NO_SPACE;
               end else begin
                  granted_in   = top_entry;
                  head_in      = head_plus;
                  alloc_tot_in = alloc_tot_ff + 1'b1;
                  alloc_ok_in  = 1'b1;
                  if (head_plus > hwm_ff) begin
                     hwm_in = head_plus;
                  end
               end
            end
            ACT_FREE: begin
               if ((32'(idx_ff) >= 32'(sc_ff)) || (head_ff == '0)) begin
                  status_in = STAT_INVALID;
               end else begin
                  head_in     = head_m1;
                  wr_en       = 1'b1;
                  free_tot_in = free_tot_ff + 1'b1;
               end
            end
            ACT_CLEAR_STATS: begin
               alloc_tot_in = '0;
               free_tot_in  = '0;
               fail_tot_in  = '0;
               peak_in      = '0;
            end
            ACT_MAINT: ;
         endcase
      end

      // Raise the peak after a granted alloc
      if (cmd.finish && alloc_ok_ff && (usage > peak_ff)) begin
         peak_in = usage;
      end
   end

   // Restoring division of used*100 by sector count, two quotient bits per step
   assign num     = NUM_W'(head_in) * NUM_W'(PCT_SCALE);
   assign rem_ext = DSH_W'(rem_ff);
   assign dsh_lo  = dsh_ff >> 1;
   assign b1      = (rem_ext >= dsh_ff);
   assign r1      = b1 ? (rem_ext - dsh_ff) : rem_ext;
   assign b0      = (r1 >= dsh_lo);
   assign r0      = b0 ? (r1 - dsh_lo) : r1;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      priority if (cmd.exec) begin
         rem_in = num;
         dsh_in = DSH_W'(sc_ff) << (QUO_W - 1);
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = NUM_W'(r0);
         dsh_in = dsh_ff >> 2;
         quo_in = {quo_ff[QUO_W-3:0], b1, b0};
      end
   end

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= CNT_W'(CNT_RESET);
         thr_ff       <= '0;
         pen_ff       <= 1'b0;
         head_ff      <= '0;
         hwm_ff       <= '0;
         alloc_tot_ff <= '0;
         free_tot_ff  <= '0;
         fail_tot_ff  <= '0;
         peak_ff      <= '0;
      end else begin
         sc_ff        <= sc_in;
         thr_ff       <= thr_in;
         pen_ff       <= pen_in;
         head_ff      <= head_in;
         hwm_ff       <= hwm_in;
         alloc_tot_ff <= alloc_tot_in;
         free_tot_ff  <= free_tot_in;
         fail_tot_ff  <= fail_tot_in;
         peak_ff      <= peak_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_data.action;
         idx_ff <= req_data.free_idx;
      end
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      alloc_ok_ff <= alloc_ok_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      if (cmd.finish) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.alloc_index   <= INDEX_W'(granted_ff);
         rsp_ff.free_count    <= COUNT_W'(sc_ff - head_ff);
         rsp_ff.used_count    <= COUNT_W'(head_ff);
         rsp_ff.used_pct      <= usage;
         rsp_ff.peak_percent  <= peak_in;
         rsp_ff.pressure      <= press;
         rsp_ff.alloc_total   <= alloc_tot_ff;
         rsp_ff.free_total    <= free_tot_ff;
         rsp_ff.fail_total    <= fail_tot_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/sfla_checker.sv =====
// Port-level checks for the sector free-list allocator, bound to the top level
`include "sector_free_list_allocator_macros.svh"

module sfla_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sfla_pkg::rsp_type rsp_data
);
   import sfla_pkg::*;

   logic rsp_stall;
   logic req_take;
   logic pct_ok;
   logic is_fail;
   logic fail_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign pct_ok    = (rsp_data.used_pct <= PCT_W'(PCT_SCALE))
                   && (rsp_data.peak_percent <= PCT_W'(PCT_SCALE));
   assign is_fail   = rsp_valid && (rsp_data.status == STAT_NO_SPACE);
   assign fail_ok   = (rsp_data.alloc_index == '0) && !rsp_data.pressure
                   && (rsp_data.free_count == '0);

   // Stalled result holds
   `SFLA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // One request in flight: no accept right after an accept
   `SFLA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, !req_ready)

   // Percentages stay within scale
   `SFLA_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid, pct_ok)

   // A refused alloc grants nothing, shows a full pool and no pressure
   `SFLA_ASSERT_NOW(a_fail_shape, clock, reset, is_fail, fail_ok)

endmodule

bind sector_free_list_allocator sfla_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
